// ===== rtl/rrss_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_pkg: shared types and constants for the round-robin sleep scheduler
// Command codes, controller states and the controller/datapath link.
// ----------------------------------------------------------------------------
package rrss_pkg;

  // task count is fixed by the four-bit task number on the ports
  localparam int unsigned MAX_TASKS     = 16;
  localparam logic [15:0] SLICE_RST     = 16'd10;
  localparam logic [9:0]  PERIOD_RST    = 10'd10;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_YIELD  = 2'd2,
    CMD_SLEEP  = 2'd3
  } cmd_t;

  typedef enum logic [0:0] {
    REG_SLICE  = 1'b0,
    REG_PERIOD = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SLICE_RD,
    ST_SLICE_WR,
    ST_SLP_RD,
    ST_SLP_WR,
    ST_DIV,
    ST_SLP_PUT,
    ST_HEAD_RD,
    ST_DISPATCH,
    ST_RESULT
  } state_t;

  // controller -> datapath commands
  typedef struct packed {
    logic load;       // latch input beat
    logic decode;     // handle create/yield/sleep-pop
    logic slice_rd;
    logic slice_wr;
    logic slp_rd;
    logic slp_wr;
    logic div_start;
    logic slp_put;
    logic head_rd;
    logic dispatch;
    logic out_load;
  } dp_cmd_t;

  // datapath -> controller status
  typedef struct packed {
    cmd_t cmd;
    logic idle;
    logic slp_more;   // sleeper walk not finished
    logic div_done;
    logic reject;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== rtl/round_robin_sleep_scheduler_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// round_robin_sleep_scheduler_unit: round-robin scheduler with sleep
// Top level: sequencer, datapath and the output register.
// ----------------------------------------------------------------------------
// channel | direction | signals
// in      | input     | in_valid/in_ready, cmd, task_id, sleep_ms
// out     | output    | out_valid/out_ready, running_task .. rejected
// cfg     | input     | cfg_we, cfg_addr, cfg_wdata
//
// Each command is stepped through the datapath; tick adds a read and a
// write per sleeper, the sleeper walk over the single-port counter store,
// and sleep waits on the one-bit-per-cycle divider. A new command is taken
// only once the last result is loaded. Results wait in an output register;
// a stalled output holds the sequencer before it loads the next result.
// rst is synchronous and clears all control state; no clearing pass.
module round_robin_sleep_scheduler_unit
  import rrss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [3:0]  task_id,
  input  wire logic [31:0] sleep_ms,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       running_task,
  output logic             idle_running,
  output logic             switched,
  output logic [4:0]       ready_total,
  output logic             rejected,
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [15:0] cfg_wdata
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;
  logic [3:0] r_task;
  logic r_idle, r_sw, r_rej;
  logic [4:0] r_total;

  rrss_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .out_busy (out_valid && !out_ready),
    .stat (dstat), .cmd (dcmd)
  );

  rrss_dp u_dp (
    .clk, .rst, .cfg_we, .cfg_idx (cfg_addr), .cfg_data (cfg_wdata),
    .in_cmd (cmd), .in_task_id (task_id), .in_sleep_ms (sleep_ms),
    .cmd (dcmd), .stat (dstat),
    .res_task (r_task), .res_idle (r_idle), .res_sw (r_sw),
    .res_total (r_total), .res_rej (r_rej)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (dcmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (dcmd.out_load) begin
      running_task <= r_task;
      idle_running <= r_idle;
      switched     <= r_sw;
      ready_total  <= r_total;
      rejected     <= r_rej;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/rrss_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_ctrl: scheduler sequencer
// Steps each command through the datapath one memory access at a time.
// ----------------------------------------------------------------------------
module rrss_ctrl
  import rrss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  state_t state, state_next;

  // hold state
  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // advance
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:     if (in_valid) state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (stat.cmd)
          CMD_CREATE: state_next = ST_RESULT;
          CMD_TICK:   state_next = stat.idle ? ST_SLP_RD : ST_SLICE_RD;
          CMD_YIELD:  state_next = ST_HEAD_RD;
          CMD_SLEEP:  state_next = stat.reject ? ST_RESULT : ST_DIV;
          default:    state_next = ST_RESULT;
        endcase
      end
      ST_SLICE_RD: state_next = ST_SLICE_WR;
      ST_SLICE_WR: state_next = ST_SLP_RD;
      ST_SLP_RD:   state_next = stat.slp_more ? ST_SLP_WR : ST_HEAD_RD;
      ST_SLP_WR:   state_next = ST_SLP_RD;
      ST_DIV:      if (stat.div_done) state_next = ST_SLP_PUT;
      ST_SLP_PUT:  state_next = ST_HEAD_RD;
      ST_HEAD_RD:  state_next = ST_DISPATCH;
      ST_DISPATCH: state_next = ST_RESULT;
      ST_RESULT:   if (!out_busy) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // drive commands
  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_DECODE:   begin
        cmd.decode = 1'b1;
        cmd.div_start = (stat.cmd == CMD_SLEEP) && !stat.reject;
      end
      ST_SLICE_RD: cmd.slice_rd = 1'b1;
      ST_SLICE_WR: cmd.slice_wr = 1'b1;
      ST_SLP_RD:   cmd.slp_rd = 1'b1;
      ST_SLP_WR:   cmd.slp_wr = 1'b1;
      ST_DIV:      ;
      ST_SLP_PUT:  cmd.slp_put = 1'b1;
      ST_HEAD_RD:  cmd.head_rd = 1'b1;
      ST_DISPATCH: cmd.dispatch = 1'b1;
      ST_RESULT:   cmd.out_load = !out_busy;
      default:     ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/rrss_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_dp: scheduler datapath
// Ready FIFO, sleep list, per-task counters and a restoring divider.
// ----------------------------------------------------------------------------
module rrss_dp
  import rrss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_idx,
  input  wire logic [15:0] cfg_data,
  input  wire logic [1:0]  in_cmd,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [31:0] in_sleep_ms,
  input  wire dp_cmd_t     cmd,
  output dp_stat_t         stat,
  output logic [3:0]       res_task,
  output logic             res_idle,
  output logic             res_sw,
  output logic [4:0]       res_total,
  output logic             res_rej
);

  localparam int unsigned IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TASKS + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_TASKS);

  // configuration
  logic [15:0] slice_default;
  logic [9:0]  tick_period;
  always_ff @(posedge clk) begin
    if (rst) begin
      slice_default <= SLICE_RST;
      tick_period   <= PERIOD_RST;
    end else if (cfg_we) begin
      if (reg_idx_t'(cfg_idx) == REG_SLICE) slice_default <= cfg_data;
      else                                  tick_period   <= cfg_data[9:0];
    end
  end

  // latched beat
  cmd_t        c_cmd;
  logic [3:0]  c_id;
  logic [31:0] c_ms;
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      c_cmd <= cmd_t'(in_cmd);
      c_id  <= in_task_id;
      c_ms  <= in_sleep_ms;
    end
  end

  // memories
  logic [IW-1:0] ready_fifo  [MAX_TASKS];
  logic [IW-1:0] sleep_order [MAX_TASKS];
  logic [31:0]   sleep_left  [MAX_TASKS];
  logic [15:0]   slice_left  [MAX_TASKS];
  logic [MAX_TASKS-1:0] task_exists;

  logic [IW-1:0] head, cur, walk_t;
  logic [CW-1:0] rlen, slen, walk_i, kept;
  logic          idle, sw, rej;
  logic [IW-1:0] head_q;     // registered FIFO head read
  logic [15:0]   slice_q;    // registered slice read

  // divider: ticks = ceil(ms/per), with ms raised to at least one period
  logic [9:0]  per;
  logic [31:0] quo;
  logic [10:0] rem;
  logic [5:0]  dcnt;
  logic        dbusy;
  logic [10:0] rem_sh;
  assign per    = (tick_period == '0) ? 10'd1 : tick_period;
  assign rem_sh = {rem[9:0], quo[31]};

  logic id_ok;
  assign id_ok = (32'(c_id) < 32'(MAX_TASKS));
  logic [IW-1:0] cid;
  assign cid = c_id[IW-1:0];

  // tail index
  function automatic logic [IW-1:0] tail_at(input logic [IW-1:0] h,
                                            input logic [CW-1:0] n);
    logic [CW:0] s;
    s = {1'b0, {(CW-IW){1'b0}}, h} + {1'b0, n};
    return IW'(s % (CW+1)'(MAX_TASKS));
  endfunction

  logic [IW-1:0] head_inc;
  assign head_inc = IW'(({1'b0, head} + (IW+1)'(1)) % (IW+1)'(MAX_TASKS));

  // command execution
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0; rlen <= '0; slen <= '0; cur <= '0; idle <= 1'b1;
      task_exists <= '0; dbusy <= 1'b0; sw <= 1'b0; rej <= 1'b0;
      walk_i <= '0; kept <= '0;
    end else begin
      if (cmd.load) begin
        sw <= 1'b0; rej <= 1'b0; walk_i <= '0; kept <= '0;
      end
      if (cmd.decode) begin
        case (c_cmd)
          CMD_CREATE: begin
            if (!id_ok || task_exists[cid]) rej <= 1'b1;
            else begin
              task_exists[cid] <= 1'b1;
              slice_left[cid]  <= slice_default;
              if (rlen < FULL) begin
                ready_fifo[tail_at(head, rlen)] <= cid;
                rlen <= rlen + CW'(1);
              end
            end
          end
          CMD_YIELD: begin
            if (rlen > CW'(1)) begin
              if (!idle) begin
                ready_fifo[tail_at(head, rlen)] <= ready_fifo[head];
                head <= head_inc;
              end
            end else rej <= 1'b0;
          end
          CMD_SLEEP: begin
            if (idle || rlen == '0) rej <= 1'b1;
            else begin
              walk_t <= ready_fifo[head];
              head <= head_inc;
              rlen <= rlen - CW'(1);
            end
          end
          default: ;
        endcase
      end
      // start division; ms raised to one period first
      if (cmd.div_start) begin
        quo   <= (c_ms < 32'(per)) ? 32'(per) : c_ms;
        rem   <= '0;
        dcnt  <= '0;
        dbusy <= 1'b1;
      end else if (dbusy) begin
        if (rem_sh >= {1'b0, per}) begin
          rem <= rem_sh - {1'b0, per};
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[30:0], 1'b0};
        end
        dcnt <= dcnt + 6'd1;
        if (dcnt == 6'd31) dbusy <= 1'b0;
      end
      // park sleeper with rounded-up tick count
      if (cmd.slp_put) begin
        sleep_left[walk_t] <= quo + ((rem != '0) ? 32'd1 : 32'd0);
        if (slen < FULL) begin
          sleep_order[slen[IW-1:0]] <= walk_t;
          slen <= slen + CW'(1);
        end
      end
      // slice countdown
      if (cmd.slice_rd) slice_q <= slice_left[cur] - 16'd1;
      if (cmd.slice_wr) begin
        if (slice_q == '0) begin
          slice_left[cur] <= slice_default;
          if (rlen != '0) begin
            ready_fifo[tail_at(head, rlen)] <= ready_fifo[head];
            head <= head_inc;
          end
        end else slice_left[cur] <= slice_q;
      end
      // sleeper walk: read then write one entry
      if (cmd.slp_rd) begin
        if (walk_i < slen) begin
          walk_t <= sleep_order[walk_i[IW-1:0]];
        end else begin
          slen <= kept;
        end
      end
      if (cmd.slp_wr) begin
        sleep_left[walk_t] <= sleep_left[walk_t] - 32'd1;
        if (sleep_left[walk_t] == 32'd1) begin
          if (rlen < FULL) begin
            ready_fifo[tail_at(head, rlen)] <= walk_t;
            rlen <= rlen + CW'(1);
          end
        end else begin
          sleep_order[kept[IW-1:0]] <= walk_t;
          kept <= kept + CW'(1);
        end
        walk_i <= walk_i + CW'(1);
      end
      if (cmd.head_rd) head_q <= ready_fifo[head];
      if (cmd.dispatch) begin
        if (c_cmd == CMD_TICK || (c_cmd == CMD_YIELD && rlen > CW'(1)) ||
            c_cmd == CMD_SLEEP) begin
          if (rlen == '0) begin
            if (!idle) begin idle <= 1'b1; sw <= 1'b1; end
          end else if (idle || head_q != cur) begin
            idle <= 1'b0; cur <= head_q; sw <= 1'b1;
          end
        end
      end
    end
  end

  assign stat.cmd      = c_cmd;
  assign stat.idle     = idle;
  assign stat.slp_more = (walk_i < slen);
  assign stat.div_done = !dbusy && !cmd.div_start;
  assign stat.reject   = idle || rlen == '0;

  assign res_task  = idle ? 4'd0 : 4'(cur);
  assign res_idle  = idle;
  assign res_sw    = sw;
  assign res_total = 5'(rlen);
  assign res_rej   = rej;

endmodule
`default_nettype wire

// ===== rtl/rrss_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// rrss_checker: port-level checks for the scheduler
// Watches the top-level ports and flags results that cannot occur.
// ----------------------------------------------------------------------------
module rrss_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] running_task,
  input wire logic       idle_running,
  input wire logic       switched,
  input wire logic [4:0] ready_total,
  input wire logic       rejected
);

  // idle shows task zero
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && idle_running |-> running_task == 4'd0)
    else $error("idle result with nonzero task");

  // a running task sits in the ready queue
  a_run_queued: assert property (@(posedge clk) disable iff (rst)
    out_valid && !idle_running |-> ready_total != 5'd0)
    else $error("task running with empty queue");

  // a refused command never switches
  a_rej_nosw: assert property (@(posedge clk) disable iff (rst)
    out_valid && rejected |-> !switched)
    else $error("rejected command switched");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(ready_total))
    else $error("stalled beat changed");

endmodule

bind round_robin_sleep_scheduler_unit rrss_checker u_chk (
  .clk, .rst, .out_valid, .out_ready, .running_task, .idle_running,
  .switched, .ready_total, .rejected
);
`default_nettype wire
